[sv/svg_path_segment_normalizer_core_assert.svh]
// ----------------------------------------------------------------------------
// svg path segment normalizer assertion macros
// clocked assertion wrappers shared by the queue and back rtl files, removable by NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef SVG_PATH_SEGMENT_NORMALIZER_CORE_ASSERT_SVH
`define SVG_PATH_SEGMENT_NORMALIZER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define SVGPSN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define SVGPSN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SVGPSN_ASSERT(lbl, prop, msg)
`define SVGPSN_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/svgpsn_pkg.sv]
// ----------------------------------------------------------------------------
// svgpsn_pkg
// shared types, codes and saturating arithmetic of the path segment normalizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svgpsn_pkg;

  // coordinate width, q16.16 at the default
  localparam int CoordW = 32;
  localparam int KindW  = 4;
  localparam int SegW   = 2;

  // decoupling queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef logic signed [CoordW-1:0] coord_t;

  localparam coord_t CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  // minus one in q16.16, clamped when the width cannot hold it
  localparam coord_t LastCtlRst = (CoordW >= 18) ? coord_t'(-64'sd65536) : CoordMin;

  typedef enum logic [KindW-1:0] {
    CMD_M_ABS   = 4'd0,
    CMD_M_REL   = 4'd1,
    CMD_L_ABS   = 4'd2,
    CMD_L_REL   = 4'd3,
    CMD_H_ABS   = 4'd4,
    CMD_H_REL   = 4'd5,
    CMD_V_ABS   = 4'd6,
    CMD_V_REL   = 4'd7,
    CMD_C_ABS   = 4'd8,
    CMD_C_REL   = 4'd9,
    CMD_S_ABS   = 4'd10,
    CMD_S_REL   = 4'd11,
    CMD_Z       = 4'd12,
    CMD_UNKNOWN = 4'd13
  } cmd_t;

  typedef enum logic [SegW-1:0] {
    SEG_MOVE  = 2'd0,
    SEG_LINE  = 2'd1,
    SEG_CUBIC = 2'd2,
    SEG_CLOSE = 2'd3
  } seg_t;

  // classified segment control
  typedef struct packed {
    seg_t seg;
    logic rel;        // operands are offsets from the current point
    logic keep_x;     // end x stays at the current x
    logic keep_y;     // end y stays at the current y
    logic use_start;  // end point is the subpath start
    logic refl;       // first control is the reflected last control
  } dec_t;

  // one queue word: control plus operands sorted by role
  typedef struct packed {
    dec_t   ctl;
    coord_t c1x;
    coord_t c1y;
    coord_t c2x;
    coord_t c2y;
    coord_t ex;
    coord_t ey;
  } qword_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic coord_t sat_add(coord_t a, coord_t b);
    logic signed [CoordW:0] s;
    s = {a[CoordW-1], a} + {b[CoordW-1], b};
    if (s[CoordW] != s[CoordW-1]) begin
      sat_add = s[CoordW] ? CoordMin : CoordMax;
    end else begin
      sat_add = s[CoordW-1:0];
    end
  endfunction

  function automatic coord_t sat_sub(coord_t a, coord_t b);
    logic signed [CoordW:0] s;
    s = {a[CoordW-1], a} - {b[CoordW-1], b};
    if (s[CoordW] != s[CoordW-1]) begin
      sat_sub = s[CoordW] ? CoordMin : CoordMax;
    end else begin
      sat_sub = s[CoordW-1:0];
    end
  endfunction

endpackage

[sv/svgpsn_if.sv]
// ----------------------------------------------------------------------------
// svgpsn channel interfaces
// valid/ready channels for path segments in and absolute segments out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface svgpsn_in_if;
  logic                           valid;
  logic                           ready;
  logic [svgpsn_pkg::KindW-1:0]   kind;
  svgpsn_pkg::coord_t             p0;
  svgpsn_pkg::coord_t             p1;
  svgpsn_pkg::coord_t             p2;
  svgpsn_pkg::coord_t             p3;
  svgpsn_pkg::coord_t             p4;
  svgpsn_pkg::coord_t             p5;

  modport source (output valid, kind, p0, p1, p2, p3, p4, p5, input ready);
  modport sink   (input valid, kind, p0, p1, p2, p3, p4, p5, output ready);
endinterface

interface svgpsn_out_if;
  logic                         valid;
  logic                         ready;
  logic [svgpsn_pkg::SegW-1:0]  seg_kind;
  svgpsn_pkg::coord_t           ctl1_x;
  svgpsn_pkg::coord_t           ctl1_y;
  svgpsn_pkg::coord_t           ctl2_x;
  svgpsn_pkg::coord_t           ctl2_y;
  svgpsn_pkg::coord_t           end_x;
  svgpsn_pkg::coord_t           end_y;

  modport source (output valid, seg_kind, ctl1_x, ctl1_y, ctl2_x, ctl2_y, end_x, end_y,
                  input ready);
  modport sink   (input valid, seg_kind, ctl1_x, ctl1_y, ctl2_x, ctl2_y, end_x, end_y,
                  output ready);
endinterface

[sv/svg_path_segment_normalizer_core.sv]
// ----------------------------------------------------------------------------
// svg_path_segment_normalizer_core
// turns svg path segments (M m L l H h V v C c S s Z) into absolute move,
// line, cubic and close segments with saturating q16.16 arithmetic
// path: an accepted segment is written into the queue, then popped into the output register
// throughput: one segment per cycle while the output is not stalled
// reset: synchronous active-low; pen at origin, last control at minus one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svg_path_segment_normalizer_core (
  input  logic          clk,
  input  logic          rst_n,
  svgpsn_in_if.sink     in_ch,
  svgpsn_out_if.source  out_ch
);

  // front -> queue -> back
  logic                 q_wr_en;
  logic                 q_rd_en;
  svgpsn_pkg::qword_t   q_wr_data;
  svgpsn_pkg::qword_t   q_rd_data;
  svgpsn_pkg::q_stat_t  q_stat;

  // classify: decode the command, sort operands into control and end slots,
  // drop unknown codes without a result
  svgpsn_front u_front (
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .q_wr_en   (q_wr_en),
    .q_wr_data (q_wr_data)
  );

  // two-word queue, lets the input side keep taking words while a result stalls
  svgpsn_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  // execute: relative adds, reflection and pen state, one word per cycle into
  // the output register while the output is not stalled
  svgpsn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rd_data (q_rd_data),
    .q_stat    (q_stat),
    .q_rd_en   (q_rd_en),
    .out_ch    (out_ch)
  );

endmodule

[sv/svgpsn_front.sv]
// ----------------------------------------------------------------------------
// svgpsn_front
// accepts path segments, classifies the command and sorts operands by role
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svgpsn_front (
  svgpsn_in_if.sink               in_ch,
  input  svgpsn_pkg::q_stat_t     q_stat,
  output logic                    q_wr_en,
  output svgpsn_pkg::qword_t      q_wr_data
);

  logic known;

  assign in_ch.ready = !q_stat.full;

  always_comb begin
    q_wr_data           = '0;
    q_wr_data.ctl.seg   = svgpsn_pkg::SEG_LINE;
    known               = 1'b1;
    unique case (svgpsn_pkg::cmd_t'(in_ch.kind))
      svgpsn_pkg::CMD_M_ABS, svgpsn_pkg::CMD_M_REL: begin
        q_wr_data.ctl.seg = svgpsn_pkg::SEG_MOVE;
        q_wr_data.ctl.rel = (in_ch.kind == svgpsn_pkg::CMD_M_REL);
        q_wr_data.ex      = in_ch.p0;
        q_wr_data.ey      = in_ch.p1;
      end
      svgpsn_pkg::CMD_L_ABS, svgpsn_pkg::CMD_L_REL: begin
        q_wr_data.ctl.rel = (in_ch.kind == svgpsn_pkg::CMD_L_REL);
        q_wr_data.ex      = in_ch.p0;
        q_wr_data.ey      = in_ch.p1;
      end
      svgpsn_pkg::CMD_H_ABS, svgpsn_pkg::CMD_H_REL: begin
        q_wr_data.ctl.rel    = (in_ch.kind == svgpsn_pkg::CMD_H_REL);
        q_wr_data.ctl.keep_y = 1'b1;
        q_wr_data.ex         = in_ch.p0;
      end
      svgpsn_pkg::CMD_V_ABS, svgpsn_pkg::CMD_V_REL: begin
        q_wr_data.ctl.rel    = (in_ch.kind == svgpsn_pkg::CMD_V_REL);
        q_wr_data.ctl.keep_x = 1'b1;
        q_wr_data.ey         = in_ch.p0;
      end
      svgpsn_pkg::CMD_C_ABS, svgpsn_pkg::CMD_C_REL: begin
        q_wr_data.ctl.seg = svgpsn_pkg::SEG_CUBIC;
        q_wr_data.ctl.rel = (in_ch.kind == svgpsn_pkg::CMD_C_REL);
        q_wr_data.c1x     = in_ch.p0;
        q_wr_data.c1y     = in_ch.p1;
        q_wr_data.c2x     = in_ch.p2;
        q_wr_data.c2y     = in_ch.p3;
        q_wr_data.ex      = in_ch.p4;
        q_wr_data.ey      = in_ch.p5;
      end
      svgpsn_pkg::CMD_S_ABS, svgpsn_pkg::CMD_S_REL: begin
        // shorthand curve: four operands, first control comes from reflection
        q_wr_data.ctl.seg  = svgpsn_pkg::SEG_CUBIC;
        q_wr_data.ctl.rel  = (in_ch.kind == svgpsn_pkg::CMD_S_REL);
        q_wr_data.ctl.refl = 1'b1;
        q_wr_data.c2x      = in_ch.p0;
        q_wr_data.c2y      = in_ch.p1;
        q_wr_data.ex       = in_ch.p2;
        q_wr_data.ey       = in_ch.p3;
      end
      svgpsn_pkg::CMD_Z: begin
        q_wr_data.ctl.seg       = svgpsn_pkg::SEG_CLOSE;
        q_wr_data.ctl.use_start = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unknown commands are taken and dropped
  assign q_wr_en = in_ch.valid && in_ch.ready && known;

endmodule

[sv/svgpsn_queue.sv]
// ----------------------------------------------------------------------------
// svgpsn_queue
// short register queue that decouples the classify and execute sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "svg_path_segment_normalizer_core_assert.svh"

module svgpsn_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  svgpsn_pkg::qword_t      wr_data,
  input  logic                    rd_en,
  output svgpsn_pkg::qword_t      rd_data,
  output svgpsn_pkg::q_stat_t     stat
);

  svgpsn_pkg::qword_t                 mem_r [svgpsn_pkg::QueueDepth];
  logic [svgpsn_pkg::QPtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [svgpsn_pkg::QPtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [svgpsn_pkg::QCntW-1:0]       cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == svgpsn_pkg::QCntW'(svgpsn_pkg::QueueDepth));
  assign stat.empty = (cnt_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == svgpsn_pkg::QPtrW'(svgpsn_pkg::QueueDepth - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == svgpsn_pkg::QPtrW'(svgpsn_pkg::QueueDepth - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `SVGPSN_ASSERT(a_q_no_overflow, wr_en |-> !stat.full, "queue written while full")
  `SVGPSN_ASSERT(a_q_no_underflow, rd_en |-> !stat.empty, "queue read while empty")
  `SVGPSN_ASSERT(a_q_count_up, (wr_en && !rd_en) |=> (cnt_r == $past(cnt_r) + 1'b1), "queue count did not advance on push")

endmodule

[sv/svgpsn_back.sv]
// ----------------------------------------------------------------------------
// svgpsn_back
// executes classified segments against the pen state, registered result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "svg_path_segment_normalizer_core_assert.svh"

module svgpsn_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  svgpsn_pkg::qword_t      q_rd_data,
  input  svgpsn_pkg::q_stat_t     q_stat,
  output logic                    q_rd_en,
  svgpsn_out_if.source            out_ch
);

  // pen state
  svgpsn_pkg::coord_t cur_x_r, cur_y_r, start_x_r, start_y_r, last_x_r, last_y_r;
  svgpsn_pkg::coord_t cur_x_nxt, cur_y_nxt, start_x_nxt, start_y_nxt;
  svgpsn_pkg::coord_t last_x_nxt, last_y_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  svgpsn_pkg::seg_t   seg_r, seg_nxt;
  svgpsn_pkg::coord_t c1x_r, c1y_r, c2x_r, c2y_r, ex_r, ey_r;
  svgpsn_pkg::coord_t c1x_nxt, c1y_nxt, c2x_nxt, c2y_nxt, ex_nxt, ey_nxt;

  svgpsn_pkg::dec_t   ctl;
  logic               pop;
  logic               curve;

  assign ctl     = q_rd_data.ctl;
  assign curve   = (ctl.seg == svgpsn_pkg::SEG_CUBIC);
  assign pop     = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign q_rd_en = pop;

  always_comb begin
    // end point
    if (ctl.use_start) begin
      ex_nxt = start_x_r;
      ey_nxt = start_y_r;
    end else begin
      ex_nxt = ctl.keep_x ? cur_x_r :
               ctl.rel    ? svgpsn_pkg::sat_add(cur_x_r, q_rd_data.ex) : q_rd_data.ex;
      ey_nxt = ctl.keep_y ? cur_y_r :
               ctl.rel    ? svgpsn_pkg::sat_add(cur_y_r, q_rd_data.ey) : q_rd_data.ey;
    end

    // controls, zero for non-curves
    c1x_nxt = '0;
    c1y_nxt = '0;
    c2x_nxt = '0;
    c2y_nxt = '0;
    if (curve) begin
      if (ctl.refl) begin
        c1x_nxt = svgpsn_pkg::sat_add(cur_x_r, svgpsn_pkg::sat_sub(cur_x_r, last_x_r));
        c1y_nxt = svgpsn_pkg::sat_add(cur_y_r, svgpsn_pkg::sat_sub(cur_y_r, last_y_r));
      end else begin
        c1x_nxt = ctl.rel ? svgpsn_pkg::sat_add(cur_x_r, q_rd_data.c1x) : q_rd_data.c1x;
        c1y_nxt = ctl.rel ? svgpsn_pkg::sat_add(cur_y_r, q_rd_data.c1y) : q_rd_data.c1y;
      end
      c2x_nxt = ctl.rel ? svgpsn_pkg::sat_add(cur_x_r, q_rd_data.c2x) : q_rd_data.c2x;
      c2y_nxt = ctl.rel ? svgpsn_pkg::sat_add(cur_y_r, q_rd_data.c2y) : q_rd_data.c2y;
    end
    seg_nxt = ctl.seg;

    // state update
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    last_x_nxt  = last_x_r;
    last_y_nxt  = last_y_r;
    if (pop) begin
      cur_x_nxt = ex_nxt;
      cur_y_nxt = ey_nxt;
      if (ctl.seg == svgpsn_pkg::SEG_MOVE) begin
        start_x_nxt = ex_nxt;
        start_y_nxt = ey_nxt;
      end
      if (curve) begin
        last_x_nxt = c2x_nxt;
        last_y_nxt = c2y_nxt;
      end
    end

    out_valid_nxt = pop || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      last_x_r    <= svgpsn_pkg::LastCtlRst;
      last_y_r    <= svgpsn_pkg::LastCtlRst;
    end else begin
      out_valid_r <= out_valid_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      seg_r <= seg_nxt;
      c1x_r <= c1x_nxt;
      c1y_r <= c1y_nxt;
      c2x_r <= c2x_nxt;
      c2y_r <= c2y_nxt;
      ex_r  <= ex_nxt;
      ey_r  <= ey_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.seg_kind = seg_r;
  assign out_ch.ctl1_x   = c1x_r;
  assign out_ch.ctl1_y   = c1y_r;
  assign out_ch.ctl2_x   = c2x_r;
  assign out_ch.ctl2_y   = c2y_r;
  assign out_ch.end_x    = ex_r;
  assign out_ch.end_y    = ey_r;

  `SVGPSN_ASSERT_ALWAYS(a_bk_reset_idle, !rst_n |=> !out_valid_r, "result valid right after reset")
  `SVGPSN_ASSERT(a_bk_pen_follows, pop |=> (cur_x_r == ex_r && cur_y_r == ey_r), "current point differs from issued end point")
  `SVGPSN_ASSERT(a_bk_move_start, (pop && ctl.seg == svgpsn_pkg::SEG_MOVE) |=> (start_x_r == ex_r && start_y_r == ey_r), "subpath start not taken on move")
  `SVGPSN_ASSERT(a_bk_flat_ctl, (out_valid_r && seg_r != svgpsn_pkg::SEG_CUBIC) |-> (c1x_r == '0 && c1y_r == '0 && c2x_r == '0 && c2y_r == '0), "non-curve word carries control points")

endmodule

[test/absolute_segment_checker.sv]
// ----------------------------------------------------------------------------
// absolute segment checker
// watches both channels of the path segment normalizer, keeps its own pen,
// reflection and subpath state, and compares every output word in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module absolute_segment_checker (
  input  logic        clk,
  input  logic        rst_n,
  svgpsn_in_if        in_ch,
  svgpsn_out_if       out_ch,
  output int unsigned mismatch_count,
  output int unsigned awaited_segs,
  output int unsigned checked_segs
);
  import svgpsn_pkg::*;

  localparam int ReportLimit = 10;

  typedef struct packed {
    seg_t   seg;
    coord_t c1x;
    coord_t c1y;
    coord_t c2x;
    coord_t c2y;
    coord_t ex;
    coord_t ey;
  } abs_seg_t;

  coord_t   pen_x, pen_y;     // current point
  coord_t   refl_x, refl_y;   // last second control point
  coord_t   sub_x, sub_y;     // subpath start
  abs_seg_t expected_segs[$];

  function automatic coord_t saturate(longint v);
    if (v > longint'(CoordMax)) return CoordMax;
    if (v < longint'(CoordMin)) return CoordMin;
    return coord_t'(v);
  endfunction

  task automatic normalize_accepted();
    abs_seg_t r;
    coord_t   a0, a1, a2, a3, a4, a5;
    a0 = in_ch.p0;
    a1 = in_ch.p1;
    a2 = in_ch.p2;
    a3 = in_ch.p3;
    a4 = in_ch.p4;
    a5 = in_ch.p5;
    r  = '0;
    case (in_ch.kind)
      CMD_M_ABS: begin
        r.seg = SEG_MOVE; r.ex = a0; r.ey = a1;
      end
      CMD_M_REL: begin
        r.seg = SEG_MOVE;
        r.ex  = saturate(longint'(pen_x) + a0);
        r.ey  = saturate(longint'(pen_y) + a1);
      end
      CMD_L_ABS: begin
        r.seg = SEG_LINE; r.ex = a0; r.ey = a1;
      end
      CMD_L_REL: begin
        r.seg = SEG_LINE;
        r.ex  = saturate(longint'(pen_x) + a0);
        r.ey  = saturate(longint'(pen_y) + a1);
      end
      CMD_H_ABS: begin
        r.seg = SEG_LINE; r.ex = a0; r.ey = pen_y;
      end
      CMD_H_REL: begin
        r.seg = SEG_LINE; r.ex = saturate(longint'(pen_x) + a0); r.ey = pen_y;
      end
      CMD_V_ABS: begin
        r.seg = SEG_LINE; r.ex = pen_x; r.ey = a0;
      end
      CMD_V_REL: begin
        r.seg = SEG_LINE; r.ex = pen_x; r.ey = saturate(longint'(pen_y) + a0);
      end
      CMD_C_ABS: begin
        r.seg = SEG_CUBIC;
        r.c1x = a0; r.c1y = a1; r.c2x = a2; r.c2y = a3; r.ex = a4; r.ey = a5;
      end
      CMD_C_REL: begin
        r.seg = SEG_CUBIC;
        r.c1x = saturate(longint'(pen_x) + a0);
        r.c1y = saturate(longint'(pen_y) + a1);
        r.c2x = saturate(longint'(pen_x) + a2);
        r.c2y = saturate(longint'(pen_y) + a3);
        r.ex  = saturate(longint'(pen_x) + a4);
        r.ey  = saturate(longint'(pen_y) + a5);
      end
      CMD_S_ABS, CMD_S_REL: begin
        r.seg = SEG_CUBIC;
        // mirror of the stored control, each step clamped on its own
        r.c1x = saturate(longint'(pen_x) + saturate(longint'(pen_x) - refl_x));
        r.c1y = saturate(longint'(pen_y) + saturate(longint'(pen_y) - refl_y));
        if (in_ch.kind == CMD_S_ABS) begin
          r.c2x = a0; r.c2y = a1; r.ex = a2; r.ey = a3;
        end else begin
          r.c2x = saturate(longint'(pen_x) + a0);
          r.c2y = saturate(longint'(pen_y) + a1);
          r.ex  = saturate(longint'(pen_x) + a2);
          r.ey  = saturate(longint'(pen_y) + a3);
        end
      end
      CMD_Z: begin
        r.seg = SEG_CLOSE; r.ex = sub_x; r.ey = sub_y;
      end
      default: return;  // unknown codes leave no word and no state change
    endcase
    if (r.seg == SEG_MOVE) begin
      sub_x = r.ex;
      sub_y = r.ey;
    end
    if (r.seg == SEG_CUBIC) begin
      refl_x = r.c2x;
      refl_y = r.c2y;
    end
    pen_x = r.ex;
    pen_y = r.ey;
    expected_segs.push_back(r);
  endtask

  task automatic note_mismatch(string what, logic [CoordW-1:0] want,
                               logic [CoordW-1:0] got);
    mismatch_count++;
    if (mismatch_count <= ReportLimit)
      $display("%0t: word %0d %s expected %h got %h", $time, checked_segs, what, want, got);
  endtask

  task automatic check_result();
    abs_seg_t want;
    if (expected_segs.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit)
        $display("%0t: unexpected word kind %0d end %h,%h", $time, out_ch.seg_kind,
                 out_ch.end_x, out_ch.end_y);
      return;
    end
    want = expected_segs.pop_front();
    if (out_ch.seg_kind !== want.seg) note_mismatch("seg_kind", want.seg, out_ch.seg_kind);
    if (out_ch.ctl1_x !== want.c1x)   note_mismatch("ctl1_x", want.c1x, out_ch.ctl1_x);
    if (out_ch.ctl1_y !== want.c1y)   note_mismatch("ctl1_y", want.c1y, out_ch.ctl1_y);
    if (out_ch.ctl2_x !== want.c2x)   note_mismatch("ctl2_x", want.c2x, out_ch.ctl2_x);
    if (out_ch.ctl2_y !== want.c2y)   note_mismatch("ctl2_y", want.c2y, out_ch.ctl2_y);
    if (out_ch.end_x !== want.ex)     note_mismatch("end_x", want.ex, out_ch.end_x);
    if (out_ch.end_y !== want.ey)     note_mismatch("end_y", want.ey, out_ch.end_y);
    checked_segs++;
  endtask

  // output side first, so a word cannot be matched against a segment
  // accepted on the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      pen_x  = '0;
      pen_y  = '0;
      sub_x  = '0;
      sub_y  = '0;
      refl_x = LastCtlRst;
      refl_y = LastCtlRst;
      expected_segs.delete();
      mismatch_count = 0;
      checked_segs   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) normalize_accepted();
    end
    awaited_segs = expected_segs.size();
  end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// path segment normalizer testbench
// directed corner segments, then random well-formed subpaths with some noise,
// under three stall mixes and one long output hold; a side checker predicts
// and compares every absolute word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import svgpsn_pkg::*;

  localparam int  RandomSegs   = 650;
  localparam int  LongHold     = 300;     // output stall, long enough to back up the input
  localparam int  CycleLimit   = 200000;
  localparam int  SettleCycles = 20;      // margin after the final drain
  localparam coord_t OneQ      = 32'sd65536;
  localparam logic [KindW-1:0] KindTop = '1;

  logic clk;
  logic rst_n;

  svgpsn_in_if  in_ch ();
  svgpsn_out_if out_ch ();

  int unsigned mismatch_count;
  int unsigned awaited_segs;
  int unsigned checked_segs;

  // stall mix: 0 sender light / receiver heavy, 1 the reverse, 2 no idling
  int idle_phase = 0;
  int sender_idle[3] = '{10, 70, 0};
  int recv_idle[3]   = '{70, 10, 0};

  int hold_req     = 0;   // bumped to ask the receiver for one long hold
  int sent_segs    = 0;
  int ignored_segs = 0;
  int cycle_count  = 0;

  svg_path_segment_normalizer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  absolute_segment_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .awaited_segs   (awaited_segs),
    .checked_segs   (checked_segs)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random ready, or a long hold counted out here
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle[idle_phase]);
      end
    end
  end

  // mostly modest coordinates so paths stay in range, with extremes mixed in
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 15))
      0:       return CoordMax;
      1:       return CoordMin;
      2, 3:    return coord_t'($urandom);
      4:       return CoordMax - coord_t'($urandom_range(0, 65535));
      5:       return CoordMin + coord_t'($urandom_range(0, 65535));
      default: return coord_t'($urandom_range(0, 1 << 23)) - coord_t'(1 << 22);
    endcase
  endfunction

  // offer one segment word, idling first at the current rate; returns at
  // the falling edge after the word is taken, valid still high
  task automatic send_seg(input logic [KindW-1:0] kind, input coord_t a0, input coord_t a1,
                          input coord_t a2, input coord_t a3, input coord_t a4,
                          input coord_t a5);
    while ($urandom_range(0, 99) < sender_idle[idle_phase]) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.p0    <= a0;
    in_ch.p1    <= a1;
    in_ch.p2    <= a2;
    in_ch.p3    <= a3;
    in_ch.p4    <= a4;
    in_ch.p5    <= a5;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (kind >= CMD_UNKNOWN) ignored_segs++;
    else sent_segs++;
  endtask

  task automatic send_random(input logic [KindW-1:0] kind);
    send_seg(kind, pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
             pick_coord());
  endtask

  // one subpath: a move, a run of drawing commands, usually a close
  task automatic random_path();
    int n;
    n = $urandom_range(1, 8);
    send_random($urandom_range(0, 1) ? CMD_M_ABS : CMD_M_REL);
    repeat (n) send_random(KindW'($urandom_range(CMD_L_ABS, CMD_S_REL)));
    if ($urandom_range(0, 9) < 7) send_random(CMD_Z);
  endtask

  task automatic wait_drained();
    while (awaited_segs != 0) @(negedge clk);
  endtask

  initial begin
    int target;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind  = CMD_M_ABS;
    in_ch.p0    = '0;
    in_ch.p1    = '0;
    in_ch.p2    = '0;
    in_ch.p3    = '0;
    in_ch.p4    = '0;
    in_ch.p5    = '0;
    // count rising edges so the reset length does not hinge on time zero
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners
    // shorthand straight out of reset mirrors the reset control point
    send_seg(CMD_S_ABS, OneQ, OneQ, 2 * OneQ, -OneQ, CoordMax, CoordMin);
    send_seg(CMD_S_REL, -OneQ, OneQ, OneQ, -OneQ, CoordMin, CoordMax);
    send_seg(CMD_M_ABS, CoordMax, CoordMin, CoordMax, CoordMin, CoordMax, CoordMin);
    // relative adds that clamp at both ends
    send_seg(CMD_L_REL, CoordMax, CoordMin, '0, '0, '0, '0);
    send_seg(CMD_H_REL, CoordMin, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax);
    send_seg(CMD_V_REL, CoordMax, CoordMin, '0, '0, '0, '0);
    send_seg(CMD_H_ABS, CoordMin, CoordMax, '0, '0, '0, '0);
    send_seg(CMD_V_ABS, CoordMax, CoordMin, '0, '0, '0, '0);
    send_seg(CMD_L_ABS, '0, '0, CoordMin, CoordMin, CoordMin, CoordMin);
    send_seg(CMD_M_REL, CoordMin, CoordMax, '0, '0, '0, '0);
    send_seg(CMD_C_ABS, CoordMax, CoordMin, CoordMin, CoordMax, '0, -OneQ);
    // reflection whose difference overflows before the final add
    send_seg(CMD_S_ABS, OneQ, -OneQ, CoordMax, CoordMin, '0, '0);
    send_seg(CMD_C_REL, CoordMax, CoordMax, CoordMin, CoordMin, OneQ, OneQ);
    send_seg(CMD_S_REL, CoordMin, CoordMax, -OneQ, OneQ, CoordMax, CoordMax);
    // close returns to the subpath start, twice in a row
    send_seg(CMD_Z, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax, CoordMax);
    send_seg(CMD_Z, '0, '0, '0, '0, '0, '0);
    // codes past the last command are dropped
    for (int k = CMD_UNKNOWN; k <= KindTop; k++) send_random(KindW'(k));
    send_seg(CMD_M_ABS, -OneQ, OneQ, '0, '0, '0, '0);
    send_seg(CMD_L_ABS, OneQ, -OneQ, '0, '0, '0, '0);
    send_seg(CMD_Z, '0, '0, '0, '0, '0, '0);
    in_ch.valid <= 1'b0;
    wait_drained();   // sender holds back until every word has come out

    // random subpaths under each stall mix; the fully loaded mix starts
    // with a long output hold while the sender keeps offering
    for (int ph = 0; ph < 3; ph++) begin
      idle_phase = ph;
      if (ph == 2) hold_req++;
      target = sent_segs + RandomSegs / 3;
      while (sent_segs < target) begin
        if ($urandom_range(0, 9) == 0) send_random(KindW'($urandom_range(0, KindTop)));
        else random_path();
      end
      in_ch.valid <= 1'b0;
      wait_drained();
    end

    repeat (SettleCycles) @(negedge clk);
    $display("drove %0d segments and %0d words with unknown codes over every command",
             sent_segs, ignored_segs);
    $display("checked %0d absolute words across three stall mixes and one long hold",
             checked_segs);
    if (mismatch_count == 0 && awaited_segs == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[svg_path_segment_normalizer_core.f]
+incdir+sv
sv/svgpsn_pkg.sv
sv/svgpsn_if.sv
sv/svgpsn_front.sv
sv/svgpsn_queue.sv
sv/svgpsn_back.sv
sv/svg_path_segment_normalizer_core.sv
test/absolute_segment_checker.sv
test/testbench.sv
